/* src/grt_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the generational rectangle table.
// Used by grt_ctrl, grt_dpath and generational_rect_table_top; no dependencies.
package grt_pkg;

  // Defaults for the top-level parameters
  localparam int SLOTS_DEF      = 64;
  localparam int COORD_BITS_DEF = 16;

  // Fixed port field widths
  localparam int REQ_W    = 2;
  localparam int SLOT_W   = 6;
  localparam int GEN_W    = 16;
  localparam int COORD_W  = 16;
  localparam int ATTR_W   = 32;
  localparam int STATUS_W = 2;
  localparam int CURSOR_W = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE  = 2'd0,
    REQ_DESTROY = 2'd1,
    REQ_LOOKUP  = 2'd2,
    REQ_QUERY   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_STALE = 2'd1,
    ST_FULL  = 2'd2,
    ST_NOHIT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RESP,
    S_SCAN,
    S_FLUSH
  } state_t;

  // Which result word the datapath loads into the output register
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_CREATE,
    EMIT_FULL,
    EMIT_LOOKUP,
    EMIT_PEND,
    EMIT_PEND_LAST,
    EMIT_NOHIT
  } emit_t;

  // Controller to datapath
  typedef struct packed {
    logic  latch_req;
    logic  exec_read;
    logic  scan_adv;
    logic  destroy_write;
    emit_t emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    req_t req;
    logic out_free;
    logic create_full;
    logic scan_done;
    logic hit;
    logic pend_valid;
  } stat_t;

endpackage

/* src/generational_rect_table_top.sv */
`timescale 1ns / 1ps
// Top level of the generational rectangle table: controller plus datapath.
// Depends on grt_pkg, grt_ctrl and grt_dpath.
//
// A table of SLOTS rectangles addressed by (slot, generation) handles. One request word
// is taken at a time. Create, lookup and destroy go through the same steps: accept, one
// read of the slot stores, then respond or write. Create and lookup load a result word
// into the output register once it is free; destroy gives no result. An overlap query
// reads one slot per cycle through the single read port of each store, but holds the
// scan while a held hit cannot leave the output register. Its steps are: accept, SLOTS
// reads, a test of the last slot, a check for the scan end, then the final word. A new
// word waits while the output register still holds a stalled word; hits come out in
// ascending slot order and the last word of each request has last set. The next request
// is accepted while the final result word still waits in the output register. Per-slot
// flags in flops give the reset state at once, so there is no clearing pass after reset.
module generational_rect_table_top #(
  parameter int SLOTS      = grt_pkg::SLOTS_DEF,
  parameter int COORD_BITS = grt_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [grt_pkg::REQ_W-1:0]          req_type,
  input  logic [grt_pkg::SLOT_W-1:0]         slot_index,
  input  logic [grt_pkg::GEN_W-1:0]          generation_in,
  input  logic signed [grt_pkg::COORD_W-1:0] rect_x,
  input  logic signed [grt_pkg::COORD_W-1:0] rect_y,
  input  logic [grt_pkg::COORD_W-1:0]        rect_w,
  input  logic [grt_pkg::COORD_W-1:0]        rect_h,
  input  logic [grt_pkg::ATTR_W-1:0]         attr_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [grt_pkg::STATUS_W-1:0]       status,
  output logic [grt_pkg::SLOT_W-1:0]         out_slot,
  output logic [grt_pkg::GEN_W-1:0]          out_generation,
  output logic signed [grt_pkg::COORD_W-1:0] out_x,
  output logic signed [grt_pkg::COORD_W-1:0] out_y,
  output logic [grt_pkg::COORD_W-1:0]        out_w,
  output logic [grt_pkg::COORD_W-1:0]        out_h,
  output logic [grt_pkg::ATTR_W-1:0]         out_attr,
  output logic                               last
);

  grt_pkg::cmd_t  cmd;
  grt_pkg::stat_t st;

  grt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  grt_dpath #(
    .SLOTS      (SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .req_type       (req_type),
    .slot_index     (slot_index),
    .generation_in  (generation_in),
    .rect_x         (rect_x),
    .rect_y         (rect_y),
    .rect_w         (rect_w),
    .rect_h         (rect_h),
    .attr_word      (attr_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .out_slot       (out_slot),
    .out_generation (out_generation),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_w          (out_w),
    .out_h          (out_h),
    .out_attr       (out_attr),
    .last           (last)
  );

endmodule

/* src/grt_ctrl.sv */
`timescale 1ns / 1ps
// Request sequencer for the generational rectangle table.
// Depends on grt_pkg; drives grt_dpath through cmd_t and reads stat_t.
module grt_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [grt_pkg::REQ_W-1:0]   req_type,
  output logic                        in_stall,
  input  grt_pkg::stat_t              st,
  output grt_pkg::cmd_t               cmd
);

  grt_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= grt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next        = state;
    in_stall          = 1'b1;
    cmd.latch_req     = 1'b0;
    cmd.exec_read     = 1'b0;
    cmd.scan_adv      = 1'b0;
    cmd.destroy_write = 1'b0;
    cmd.emit          = grt_pkg::EMIT_NONE;
    case (state)
      grt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          if (grt_pkg::req_t'(req_type) == grt_pkg::REQ_QUERY) begin
            state_next = grt_pkg::S_SCAN;
          end else begin
            state_next = grt_pkg::S_EXEC;
          end
        end
      end
      grt_pkg::S_EXEC: begin
        // one read of all stores at the request slot or the cursor
        cmd.exec_read = 1'b1;
        state_next    = grt_pkg::S_RESP;
      end
      grt_pkg::S_RESP: begin
        case (st.req)
          grt_pkg::REQ_CREATE: begin
            if (st.out_free) begin
              cmd.emit   = st.create_full ? grt_pkg::EMIT_FULL : grt_pkg::EMIT_CREATE;
              state_next = grt_pkg::S_IDLE;
            end
          end
          grt_pkg::REQ_DESTROY: begin
            cmd.destroy_write = 1'b1;
            state_next        = grt_pkg::S_IDLE;
          end
          grt_pkg::REQ_LOOKUP: begin
            if (st.out_free) begin
              cmd.emit   = grt_pkg::EMIT_LOOKUP;
              state_next = grt_pkg::S_IDLE;
            end
          end
          default: begin
            state_next = grt_pkg::S_IDLE;
          end
        endcase
      end
      grt_pkg::S_SCAN: begin
        // a new hit pushes the held hit out; hold the scan if that word can't leave
        if (st.scan_done) begin
          state_next = grt_pkg::S_FLUSH;
        end else if (st.hit && st.pend_valid) begin
          if (st.out_free) begin
            cmd.emit     = grt_pkg::EMIT_PEND;
            cmd.scan_adv = 1'b1;
          end
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      grt_pkg::S_FLUSH: begin
        if (st.out_free) begin
          cmd.emit   = st.pend_valid ? grt_pkg::EMIT_PEND_LAST : grt_pkg::EMIT_NOHIT;
          state_next = grt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = grt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* src/grt_dpath.sv */
`timescale 1ns / 1ps
// Slot stores, request registers, overlap test and output register.
// Depends on grt_pkg; commanded by grt_ctrl.
module grt_dpath #(
  parameter int SLOTS      = grt_pkg::SLOTS_DEF,
  parameter int COORD_BITS = grt_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  grt_pkg::cmd_t                     cmd,
  output grt_pkg::stat_t                    st,
  input  logic [grt_pkg::REQ_W-1:0]         req_type,
  input  logic [grt_pkg::SLOT_W-1:0]        slot_index,
  input  logic [grt_pkg::GEN_W-1:0]         generation_in,
  input  logic signed [grt_pkg::COORD_W-1:0] rect_x,
  input  logic signed [grt_pkg::COORD_W-1:0] rect_y,
  input  logic [grt_pkg::COORD_W-1:0]       rect_w,
  input  logic [grt_pkg::COORD_W-1:0]       rect_h,
  input  logic [grt_pkg::ATTR_W-1:0]        attr_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [grt_pkg::STATUS_W-1:0]      status,
  output logic [grt_pkg::SLOT_W-1:0]        out_slot,
  output logic [grt_pkg::GEN_W-1:0]         out_generation,
  output logic signed [grt_pkg::COORD_W-1:0] out_x,
  output logic signed [grt_pkg::COORD_W-1:0] out_y,
  output logic [grt_pkg::COORD_W-1:0]       out_w,
  output logic [grt_pkg::COORD_W-1:0]       out_h,
  output logic [grt_pkg::ATTR_W-1:0]        out_attr,
  output logic                              last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CW    = (COORD_BITS < grt_pkg::COORD_W) ? COORD_BITS : grt_pkg::COORD_W;
  localparam int RW    = 4 * CW;
  localparam int OW    = CW + 2;

  // Latched request
  grt_pkg::req_t                req_q;
  logic [grt_pkg::SLOT_W-1:0]   slot_q;
  logic [grt_pkg::GEN_W-1:0]    gen_in_q;
  logic signed [CW-1:0]         qx, qy;
  logic [CW-1:0]                qw, qh;
  logic [grt_pkg::ATTR_W-1:0]   attr_q;

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_q    <= grt_pkg::req_t'(req_type);
      slot_q   <= slot_index;
      gen_in_q <= generation_in;
      qx       <= rect_x[CW-1:0];
      qy       <= rect_y[CW-1:0];
      qw       <= rect_w[CW-1:0];
      qh       <= rect_h[CW-1:0];
      attr_q   <= attr_word;
    end
  end

  // Slot stores: memories plus per-slot flags in flops
  logic [RW-1:0]                rect_mem [SLOTS];
  logic [grt_pkg::ATTR_W-1:0]   attr_mem [SLOTS];
  logic [grt_pkg::GEN_W-1:0]    gen_mem  [SLOTS];
  logic [SLOTS-1:0]             occ;      // occupied; also marks rect as written
  logic [SLOTS-1:0]             attr_ok;  // attribute written at least once
  logic [SLOTS-1:0]             gen_ok;   // generation written at least once
  logic [grt_pkg::CURSOR_W-1:0] cursor;
  logic [IDX_W-1:0]             cursor_idx;
  logic [IDX_W-1:0]             slot_idx;

  assign cursor_idx = cursor[IDX_W-1:0];
  assign slot_idx   = slot_q[IDX_W-1:0];

  // Read port, shared address for all three memories
  logic [grt_pkg::CURSOR_W-1:0] rd_sel;
  logic                         rd_ok;
  logic                         rd_en;
  logic [IDX_W-1:0]             rd_addr;
  logic [CNT_W-1:0]             scan_addr;

  always_comb begin
    if (cmd.exec_read) begin
      rd_sel = (req_q == grt_pkg::REQ_CREATE) ? cursor : grt_pkg::CURSOR_W'(slot_q);
    end else begin
      rd_sel = grt_pkg::CURSOR_W'(scan_addr);
    end
  end

  assign rd_ok   = (rd_sel < SLOTS);
  assign rd_en   = (cmd.exec_read || cmd.scan_adv) && rd_ok;
  assign rd_addr = rd_sel[IDX_W-1:0];

  logic [RW-1:0]              rect_rd;
  logic [grt_pkg::ATTR_W-1:0] attr_rd;
  logic [grt_pkg::GEN_W-1:0]  gen_rd;
  logic [IDX_W-1:0]           rd_idx;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rect_rd <= rect_mem[rd_addr];
      attr_rd <= attr_mem[rd_addr];
      gen_rd  <= gen_mem[rd_addr];
      rd_idx  <= rd_addr;
    end
  end

  // Unwritten entries read as zero; a freed slot's rect also reads as zero
  logic [RW-1:0]              rect_v;
  logic [grt_pkg::ATTR_W-1:0] attr_v;
  logic [grt_pkg::GEN_W-1:0]  gen_v;

  assign rect_v = occ[rd_idx]     ? rect_rd : '0;
  assign attr_v = attr_ok[rd_idx] ? attr_rd : '0;
  assign gen_v  = gen_ok[rd_idx]  ? gen_rd  : '0;

  logic create_write;
  logic destroy_ok;

  assign create_write = (cmd.emit == grt_pkg::EMIT_CREATE);
  assign destroy_ok   = cmd.destroy_write && (slot_q < SLOTS);

  // Memory writes
  always_ff @(posedge clk) begin
    if (create_write) begin
      rect_mem[cursor_idx] <= {qh, qw, qy, qx};
      attr_mem[cursor_idx] <= attr_q;
    end
    if (destroy_ok) begin
      gen_mem[slot_idx] <= gen_v + grt_pkg::GEN_W'(1);
    end
  end

  // Flags and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      occ     <= '0;
      attr_ok <= '0;
      gen_ok  <= '0;
      cursor  <= '0;
    end else if (create_write) begin
      occ[cursor_idx]     <= 1'b1;
      attr_ok[cursor_idx] <= 1'b1;
      cursor              <= cursor + grt_pkg::CURSOR_W'(1);
    end else if (destroy_ok) begin
      occ[slot_idx]    <= 1'b0;
      gen_ok[slot_idx] <= 1'b1;
      cursor           <= grt_pkg::CURSOR_W'(slot_q);
    end
  end

  // Scan pointer and test-stage valid
  logic tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      tvalid    <= 1'b0;
    end else if (cmd.latch_req) begin
      scan_addr <= '0;
      tvalid    <= 1'b0;
    end else if (cmd.scan_adv) begin
      tvalid <= rd_ok;
      if (scan_addr != CNT_W'(SLOTS)) begin
        scan_addr <= scan_addr + CNT_W'(1);
      end
    end
  end

  // Strict overlap test on the entry held in the read register
  logic signed [OW-1:0] ax, ay, aw, ah, bx, by, bw, bh;
  logic                 hit_now;

  always_comb begin
    ax = OW'(qx);
    ay = OW'(qy);
    aw = $signed({2'b00, qw});
    ah = $signed({2'b00, qh});
    bx = OW'($signed(rect_v[CW-1:0]));
    by = OW'($signed(rect_v[2*CW-1:CW]));
    bw = $signed({2'b00, rect_v[3*CW-1:2*CW]});
    bh = $signed({2'b00, rect_v[4*CW-1:3*CW]});
    hit_now = tvalid && occ[rd_idx]
              && (ax < bx + bw) && (ax + aw > bx)
              && (ay < by + bh) && (ay + ah > by);
  end

  // Held hit: sent once the next hit or the end of scan shows whether it is last
  logic                       pend_valid;
  logic [IDX_W-1:0]           pend_slot;
  logic [grt_pkg::GEN_W-1:0]  pend_gen;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.latch_req) begin
      pend_valid <= 1'b0;
    end else if (cmd.scan_adv && hit_now) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_adv && hit_now) begin
      pend_slot <= rd_idx;
      pend_gen  <= gen_v;
    end
  end

  // Status to controller
  logic out_free;
  logic create_full;
  logic stale;

  assign out_free    = !out_valid || !out_stall;
  assign create_full = (cursor >= SLOTS) ? 1'b1 : occ[cursor_idx];
  assign stale       = (slot_q >= SLOTS) || (gen_v != gen_in_q);

  assign st.req         = req_q;
  assign st.out_free    = out_free;
  assign st.create_full = create_full;
  assign st.scan_done   = !tvalid && (scan_addr == CNT_W'(SLOTS));
  assign st.hit         = hit_now;
  assign st.pend_valid  = pend_valid;

  // Next result word
  grt_pkg::status_t            o_status;
  logic [grt_pkg::SLOT_W-1:0]  o_slot;
  logic [grt_pkg::GEN_W-1:0]   o_gen;
  logic [RW-1:0]               o_rect;
  logic [grt_pkg::ATTR_W-1:0]  o_attr;
  logic                        o_last;

  always_comb begin
    o_status = grt_pkg::ST_OK;
    o_slot   = '0;
    o_gen    = '0;
    o_rect   = '0;
    o_attr   = '0;
    o_last   = 1'b1;
    case (cmd.emit)
      grt_pkg::EMIT_CREATE: begin
        o_slot = cursor[grt_pkg::SLOT_W-1:0];
        o_gen  = gen_v;
      end
      grt_pkg::EMIT_FULL: begin
        o_status = grt_pkg::ST_FULL;
      end
      grt_pkg::EMIT_LOOKUP: begin
        if (stale) begin
          o_status = grt_pkg::ST_STALE;
        end else begin
          o_slot = slot_q;
          o_gen  = gen_in_q;
          o_rect = rect_v;
          o_attr = attr_v;
        end
      end
      grt_pkg::EMIT_PEND: begin
        o_slot = grt_pkg::SLOT_W'(pend_slot);
        o_gen  = pend_gen;
        o_last = 1'b0;
      end
      grt_pkg::EMIT_PEND_LAST: begin
        o_slot = grt_pkg::SLOT_W'(pend_slot);
        o_gen  = pend_gen;
      end
      grt_pkg::EMIT_NOHIT: begin
        o_status = grt_pkg::ST_NOHIT;
      end
      default: begin
        o_last = 1'b1;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != grt_pkg::EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != grt_pkg::EMIT_NONE) begin
      status         <= o_status;
      out_slot       <= o_slot;
      out_generation <= o_gen;
      out_x          <= grt_pkg::COORD_W'($signed(o_rect[CW-1:0]));
      out_y          <= grt_pkg::COORD_W'($signed(o_rect[2*CW-1:CW]));
      out_w          <= grt_pkg::COORD_W'(o_rect[3*CW-1:2*CW]);
      out_h          <= grt_pkg::COORD_W'(o_rect[4*CW-1:3*CW]);
      out_attr       <= o_attr;
      last           <= o_last;
    end
  end

  // Checks
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit != grt_pkg::EMIT_NONE) |-> (!out_valid || !out_stall))
    else $error("result word loaded while output register busy");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= SLOTS)
    else $error("allocation cursor beyond table");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    scan_addr <= SLOTS)
    else $error("scan pointer beyond table");

  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_adv && hit_now && pend_valid) |-> (rd_idx > pend_slot))
    else $error("query hits out of ascending slot order");

  a_no_emit_on_hold: assert property (@(posedge clk) disable iff (rst)
    (hit_now && pend_valid && !out_free) |-> !cmd.scan_adv)
    else $error("scan advanced past a hit that could not be sent");

endmodule

/* tb/sv/generational_rect_table_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for generational_rect_table_top: directed and random traffic.
// Depends on grt_pkg and generational_rect_table_top; the response predictor is local.
module generational_rect_table_top_test;
  import grt_pkg::*;

  localparam int NSLOTS        = SLOTS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 3_000_000;

  // One response word as the table should produce it
  typedef struct {
    status_t                   st;
    logic [SLOT_W-1:0]         slot;
    logic [GEN_W-1:0]          gen;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COORD_W-1:0]        w;
    logic [COORD_W-1:0]        h;
    logic [ATTR_W-1:0]         attr;
    logic                      fin;
  } table_response_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [REQ_W-1:0]          req_type = '0;
  logic [SLOT_W-1:0]         slot_index = '0;
  logic [GEN_W-1:0]          generation_in = '0;
  logic signed [COORD_W-1:0] rect_x = '0;
  logic signed [COORD_W-1:0] rect_y = '0;
  logic [COORD_W-1:0]        rect_w = '0;
  logic [COORD_W-1:0]        rect_h = '0;
  logic [ATTR_W-1:0]         attr_word = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [STATUS_W-1:0]       status;
  logic [SLOT_W-1:0]         out_slot;
  logic [GEN_W-1:0]          out_generation;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic [COORD_W-1:0]        out_w;
  logic [COORD_W-1:0]        out_h;
  logic [ATTR_W-1:0]         out_attr;
  logic                      last;

  // Shadow copy of the slot table
  logic [63:0]         tbl_rect [NSLOTS];
  logic [ATTR_W-1:0]   tbl_attr [NSLOTS];
  logic [GEN_W-1:0]    tbl_gen  [NSLOTS];
  logic                tbl_used [NSLOTS];
  logic [CURSOR_W-1:0] tbl_cursor;

  table_response_t pending_responses[$];
  table_response_t head_response;
  int              err_count = 0;
  int              cycle_count = 0;
  int              send_idle_pct = 0;
  int              out_stall_pct = 0;

  generational_rect_table_top u_dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic table_response_t blank_response();
    table_response_t r;
    r.st   = ST_OK;
    r.slot = '0;
    r.gen  = '0;
    r.x    = '0;
    r.y    = '0;
    r.w    = '0;
    r.h    = '0;
    r.attr = '0;
    r.fin  = 1'b1;
    return r;
  endfunction

  // Update the shadow table and queue the response words this request causes
  task automatic apply_table_request(req_t rt, logic [SLOT_W-1:0] sl, logic [GEN_W-1:0] gn,
                                     logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                     logic [COORD_W-1:0] w, logic [COORD_W-1:0] h,
                                     logic [ATTR_W-1:0] attr);
    table_response_t r;
    table_response_t held;
    bit              have_hit;
    longint          qx, qy, qw, qh, ex, ey, ew, eh;
    r = blank_response();
    case (rt)
      REQ_CREATE: begin
        if (tbl_cursor >= NSLOTS || tbl_used[tbl_cursor[SLOT_W-1:0]]) begin
          r.st = ST_FULL;
        end else begin
          tbl_rect[tbl_cursor[SLOT_W-1:0]] = {h, w, y, x};
          tbl_attr[tbl_cursor[SLOT_W-1:0]] = attr;
          tbl_used[tbl_cursor[SLOT_W-1:0]] = 1'b1;
          r.slot     = tbl_cursor[SLOT_W-1:0];
          r.gen      = tbl_gen[tbl_cursor[SLOT_W-1:0]];
          tbl_cursor = tbl_cursor + 1'b1;
        end
        pending_responses.push_back(r);
      end
      REQ_DESTROY: begin
        // no response; attribute word survives, generation wraps
        tbl_rect[sl] = '0;
        tbl_used[sl] = 1'b0;
        tbl_cursor   = {1'b0, sl};
        tbl_gen[sl]  = tbl_gen[sl] + 1'b1;
      end
      REQ_LOOKUP: begin
        if (tbl_gen[sl] != gn) begin
          r.st = ST_STALE;
        end else begin
          r.slot = sl;
          r.gen  = gn;
          r.x    = tbl_rect[sl][15:0];
          r.y    = tbl_rect[sl][31:16];
          r.w    = tbl_rect[sl][47:32];
          r.h    = tbl_rect[sl][63:48];
          r.attr = tbl_attr[sl];
        end
        pending_responses.push_back(r);
      end
      default: begin
        // strict overlap against every occupied slot, ascending
        qx = longint'(x);
        qy = longint'(y);
        qw = longint'(w);
        qh = longint'(h);
        have_hit = 1'b0;
        for (int i = 0; i < NSLOTS; i++) begin
          if (tbl_used[i]) begin
            ex = longint'($signed(tbl_rect[i][15:0]));
            ey = longint'($signed(tbl_rect[i][31:16]));
            ew = longint'(tbl_rect[i][47:32]);
            eh = longint'(tbl_rect[i][63:48]);
            if (qx < ex + ew && qx + qw > ex && qy < ey + eh && qy + qh > ey) begin
              if (have_hit) pending_responses.push_back(held);
              held      = blank_response();
              held.slot = i[SLOT_W-1:0];
              held.gen  = tbl_gen[i];
              held.fin  = 1'b0;
              have_hit  = 1'b1;
            end
          end
        end
        if (have_hit) begin
          held.fin = 1'b1;
          pending_responses.push_back(held);
        end else begin
          r.st = ST_NOHIT;
          pending_responses.push_back(r);
        end
      end
    endcase
  endtask

  // Drive one request word, with optional idle gap, and wait for acceptance
  task automatic send_request(req_t rt, logic [SLOT_W-1:0] sl, logic [GEN_W-1:0] gn,
                              logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                              logic [COORD_W-1:0] w, logic [COORD_W-1:0] h,
                              logic [ATTR_W-1:0] attr);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    req_type      <= rt;
    slot_index    <= sl;
    generation_in <= gn;
    rect_x        <= x;
    rect_y        <= y;
    rect_w        <= w;
    rect_h        <= h;
    attr_word     <= attr;
    do @(posedge clk); while (in_stall);
    apply_table_request(rt, sl, gn, x, y, w, h, attr);
  endtask

  // Hold off until every queued response has arrived, then let a destroy finish
  task automatic wait_table_idle();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      err_count++;
    end
  endtask

  // Response checker and output-side stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_responses.size() == 0) begin
        $error("response word with nothing outstanding (slot %0d)", out_slot);
        err_count++;
      end else begin
        head_response = pending_responses.pop_front();
        check_field("status", 32'(head_response.st), 32'(status));
        check_field("out_slot", 32'(head_response.slot), 32'(out_slot));
        check_field("out_generation", 32'(head_response.gen), 32'(out_generation));
        check_field("out_x", 32'(head_response.x), 32'(out_x));
        check_field("out_y", 32'(head_response.y), 32'(out_y));
        check_field("out_w", 32'(head_response.w), 32'(out_w));
        check_field("out_h", 32'(head_response.h), 32'(out_h));
        check_field("out_attr", head_response.attr, out_attr);
        check_field("last", 32'(head_response.fin), 32'(last));
      end
    end
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  // Mostly a small window so rectangles collide; sometimes any 16-bit value
  function automatic logic signed [COORD_W-1:0] pick_pos();
    if ($urandom_range(0, 9) < 7) return 16'(int'($urandom_range(0, 400)) - 200);
    return 16'($urandom);
  endfunction

  function automatic logic [COORD_W-1:0] pick_size();
    if ($urandom_range(0, 9) < 7) return 16'($urandom_range(0, 150));
    return 16'($urandom);
  endfunction

  // First occupied slot from a random start, else the fallback
  function automatic logic [SLOT_W-1:0] pick_live_slot(logic [SLOT_W-1:0] fallback);
    logic [SLOT_W-1:0] s;
    s = 6'($urandom);
    for (int i = 0; i < NSLOTS; i++) begin
      if (tbl_used[s]) return s;
      s = s + 1'b1;
    end
    return fallback;
  endfunction

  task automatic random_request();
    int                        pick;
    req_t                      rt;
    logic [SLOT_W-1:0]         sl;
    logic [GEN_W-1:0]          gn;
    logic signed [COORD_W-1:0] x, y;
    logic [COORD_W-1:0]        w, h;
    pick = $urandom_range(0, 99);
    sl   = 6'($urandom);
    gn   = 16'($urandom);
    x    = pick_pos();
    y    = pick_pos();
    w    = pick_size();
    h    = pick_size();
    if (pick < 35) begin
      rt = REQ_CREATE;
    end else if (pick < 55) begin
      rt = REQ_DESTROY;
      if ($urandom_range(0, 9) < 7) sl = pick_live_slot(sl);
    end else if (pick < 75) begin
      rt = REQ_LOOKUP;
      if ($urandom_range(0, 9) < 7) begin
        sl = pick_live_slot(sl);
        gn = tbl_gen[sl];
      end
    end else begin
      rt = REQ_QUERY;
      // whole-plane query to get long bursts of hits
      if ($urandom_range(0, 9) < 2) begin
        x = 16'sh8000;
        y = 16'sh8000;
        w = 16'hffff;
        h = 16'hffff;
      end
    end
    send_request(rt, sl, gn, x, y, w, h, 32'($urandom));
  endtask

  // Edges of the fields, every request kind, stale handles, both full conditions
  task automatic test_basic_requests();
    send_request(REQ_LOOKUP, 6'd5, 16'd0, 16'sd0, 16'sd0, 16'd0, 16'd0, 32'd0);
    send_request(REQ_QUERY, 6'd0, 16'd0, 16'sd0, 16'sd0, 16'd100, 16'd100, 32'd0);
    send_request(REQ_CREATE, 6'd0, 16'd0, 16'sh8000, 16'sh8000, 16'hffff, 16'hffff,
                 32'hffff_ffff);
    send_request(REQ_CREATE, 6'd0, 16'd0, 16'sh7fff, 16'sh7fff, 16'd0, 16'd0, 32'd0);
    send_request(REQ_CREATE, 6'd0, 16'd0, 16'sd100, -16'sd50, 16'd10, 16'd20, 32'ha5a5_5a5a);
    send_request(REQ_LOOKUP, 6'd0, 16'd0, 16'sd0, 16'sd0, 16'd0, 16'd0, 32'd0);
    send_request(REQ_LOOKUP, 6'd2, 16'd0, 16'sd0, 16'sd0, 16'd0, 16'd0, 32'd0);
    send_request(REQ_LOOKUP, 6'd1, 16'hffff, 16'sd0, 16'sd0, 16'd0, 16'd0, 32'd0);
    send_request(REQ_QUERY, 6'd0, 16'd0, 16'sd0, 16'sd0, 16'd1, 16'd1, 32'd0);
    // touches the right edge of slot 2 only: not an overlap
    send_request(REQ_QUERY, 6'd0, 16'd0, 16'sd110, -16'sd50, 16'd5, 16'd5, 32'd0);
    send_request(REQ_QUERY, 6'd0, 16'd0, 16'sd105, -16'sd40, 16'd1, 16'd1, 32'd0);
    send_request(REQ_QUERY, 6'd0, 16'd0, 16'sh7fff, 16'sh7fff, 16'hffff, 16'hffff, 32'd0);
    send_request(REQ_DESTROY, 6'd1, 16'hffff, 16'shffff, 16'shffff, 16'hffff, 16'hffff,
                 32'hffff_ffff);
    send_request(REQ_LOOKUP, 6'd1, 16'd0, 16'sd0, 16'sd0, 16'd0, 16'd0, 32'd0);
    send_request(REQ_LOOKUP, 6'd1, 16'd1, 16'sd0, 16'sd0, 16'd0, 16'd0, 32'd0);
    send_request(REQ_CREATE, 6'd0, 16'd0, -16'sd1, -16'sd1, 16'd2, 16'd2, 32'd1);
    // cursor now sits on occupied slot 2
    send_request(REQ_CREATE, 6'd0, 16'd0, 16'sd5, 16'sd5, 16'd5, 16'd5, 32'd2);
    // free slot destroyed anyway
    send_request(REQ_DESTROY, 6'd63, 16'd0, 16'sd0, 16'sd0, 16'd0, 16'd0, 32'd0);
    send_request(REQ_CREATE, 6'd0, 16'd0, 16'sd20, 16'sd20, 16'd40, 16'd40, 32'h1234_5678);
    // cursor past the last slot
    send_request(REQ_CREATE, 6'd0, 16'd0, 16'sd0, 16'sd0, 16'd1, 16'd1, 32'd3);
    send_request(REQ_QUERY, 6'd0, 16'd0, 16'sh8000, 16'sh8000, 16'hffff, 16'hffff, 32'd0);
    send_request(REQ_LOOKUP, 6'd63, 16'd1, 16'sd0, 16'sd0, 16'd0, 16'd0, 32'd0);
    wait_table_idle();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int count);
    send_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    repeat (count) random_request();
    wait_table_idle();
  endtask

  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      tbl_rect[i] = '0;
      tbl_attr[i] = '0;
      tbl_gen[i]  = '0;
      tbl_used[i] = 1'b0;
    end
    tbl_cursor = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_basic_requests();
    test_random_traffic(0, 0, 32);
    test_random_traffic(82, 0, 32);
    test_random_traffic(0, 82, 32);
    test_random_traffic(38, 38, 32);

    wait_table_idle();
    if (err_count == 0 && pending_responses.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
src/grt_pkg.sv
src/grt_ctrl.sv
src/grt_dpath.sv
src/generational_rect_table_top.sv
tb/sv/generational_rect_table_top_test.sv
